[design/assert_macros.svh]
// Assertion helpers included by the classifier core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[design/bdpc_pkg.sv]
`default_nettype none

package bdpc_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_WIDTH       = 16;

  typedef logic [2:0] event_code_t;

  localparam event_code_t EV_NONE    = 3'd0;
  localparam event_code_t EV_PRESS   = 3'd1;
  localparam event_code_t EV_RELEASE = 3'd2;
  localparam event_code_t EV_SHORT   = 3'd3;
  localparam event_code_t EV_LONG    = 3'd4;

  // register indexes on the config port
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

  // request kinds carried on s_tuser
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;

endpackage

`default_nettype wire

[design/button_debounce_press_classifier_core.sv]
// The result of an accepted input beat is registered onto m_* in the next cycle.
// Throughput: one beat per cycle while results are taken; the single state update path is the only loop.
// The output register frees s_tready whenever the result is taken or absent.
// Reset (rst, synchronous, active high): stable/raw levels released, counters
// cleared, press timer saturated, no pending event, thresholds 20 and 1000.
`default_nettype none
`include "assert_macros.svh"

module button_debounce_press_classifier_core
  import bdpc_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [0] raw_level, [7:1] zero
  input  wire logic                 s_tuser,   // [0] req_type
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata    // [2:0] event_code, [3] is_pressed
);

  localparam int CMP_W = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic [CFG_WIDTH-1:0]   debounce_ticks;
  logic [CFG_WIDTH-1:0]   long_press_ticks;
  logic                   stable_level, stable_level_next;
  logic                   previous_raw, previous_raw_next;
  logic [TIMER_WIDTH-1:0] since_change, since_change_next;
  logic [TIMER_WIDTH-1:0] since_press, since_press_next;
  logic                   long_reported, long_reported_next;
  event_code_t            pending_code, pending_code_next;
  event_code_t            out_code, out_code_next;
  logic                   out_pressed;

  logic s_fire;
  logic raw;
  logic [CMP_W-1:0] sc_ext, sp_ext, db_ext, lp_ext;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign raw      = s_tdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_ticks   <= cfg_wdata;
        REG_LONG_PRESS: long_press_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign db_ext = CMP_W'(debounce_ticks);
  assign lp_ext = CMP_W'(long_press_ticks);

  always_comb begin
    stable_level_next  = stable_level;
    previous_raw_next  = previous_raw;
    since_change_next  = since_change;
    since_press_next   = since_press;
    long_reported_next = long_reported;
    pending_code_next  = pending_code;
    out_code_next      = EV_NONE;
    sc_ext             = '0;
    sp_ext             = '0;

    if (s_tuser == REQ_TICK) begin
      if (since_change != TIMER_MAX) since_change_next = since_change + 1'b1;
      if (since_press != TIMER_MAX)  since_press_next  = since_press + 1'b1;
      if (raw != previous_raw) begin
        previous_raw_next = raw;
        since_change_next = '0;
      end
      sc_ext = CMP_W'(since_change_next);
      sp_ext = CMP_W'(since_press_next);
      if (raw != stable_level && sc_ext >= db_ext) begin
        stable_level_next = raw;
        if (raw) begin
          since_press_next   = '0;
          long_reported_next = 1'b0;
          pending_code_next  = EV_PRESS;
          sp_ext             = '0;
        end else if (!long_reported && sp_ext < lp_ext) begin
          pending_code_next = EV_SHORT;
        end else begin
          pending_code_next = EV_RELEASE;
        end
      end
      if (stable_level_next && !long_reported_next && sp_ext >= lp_ext) begin
        long_reported_next = 1'b1;
        pending_code_next  = EV_LONG;
      end
    end else begin
      out_code_next     = pending_code;
      pending_code_next = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level  <= 1'b0;
      previous_raw  <= 1'b0;
      since_change  <= '0;
      since_press   <= TIMER_MAX;
      long_reported <= 1'b0;
      pending_code  <= EV_NONE;
      m_tvalid      <= 1'b0;
    end else begin
      if (s_fire) begin
        stable_level  <= stable_level_next;
        previous_raw  <= previous_raw_next;
        since_change  <= since_change_next;
        since_press   <= since_press_next;
        long_reported <= long_reported_next;
        pending_code  <= pending_code_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload, loaded only with an accepted beat
  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_code    <= out_code_next;
      out_pressed <= stable_level_next;
    end
  end

  assign m_tdata = {4'b0000, out_pressed, out_code};

  `ASSERT_IMPLY(a_pending_legal, clk, rst, 1'b1, pending_code <= EV_LONG)
  `ASSERT_NEXT(a_read_clears, clk, rst, s_fire && s_tuser == REQ_READ,
               pending_code == EV_NONE)
  `ASSERT_IMPLY(a_press_clears_timer, clk, rst, $rose(stable_level), since_press == '0)
  `ASSERT_NEXT(a_tick_no_event, clk, rst, s_fire && s_tuser == REQ_TICK,
               out_code == EV_NONE && out_pressed == stable_level)

endmodule

`default_nettype wire
